### design/hsld_pkg.sv
// Shared types and constants for the header sync length deframer.
// No dependencies; imported by every module of the block.
package hsld_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned OFFSET_W   = 9;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned OUT_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_HEADER  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_HEADER = 2'd1;

  localparam logic [OFFSET_W-1:0] LEN_BYTE_OFFSET   = 9'd2;
  localparam logic [OFFSET_W-1:0] FIRST_PAY_OFFSET  = 9'd3;
  localparam logic [OFFSET_W-1:0] FRAME_OVERHEAD    = 9'd3;

  typedef struct packed {
    logic [BYTE_W-1:0]   frame_byte;
    logic [OFFSET_W-1:0] byte_offset;
    logic [BYTE_W-1:0]   declared_length;
    logic                frame_last;
  } hsld_result_t;

endpackage

### design/hsld_in_reg.sv
// Input register stage for the header sync length deframer.
// Depends on hsld_pkg for the byte width.
module hsld_in_reg (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [hsld_pkg::BYTE_W-1:0] in_byte,
  input  logic                      take,
  output logic                      valid_r,
  output logic [hsld_pkg::BYTE_W-1:0] byte_r
);
  import hsld_pkg::*;

  logic valid_nxt;

  assign in_tready = !valid_r || take;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tvalid && in_tready) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      byte_r <= in_byte;
    end
  end

endmodule

### design/hsld_core.sv
// Frame state machine: header hunt, length capture and payload counting.
// Depends on hsld_pkg for widths, offsets and the result struct.
module hsld_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step_en,
  input  logic [hsld_pkg::BYTE_W-1:0] rx_byte,
  input  logic [hsld_pkg::BYTE_W-1:0] first_header,
  input  logic [hsld_pkg::BYTE_W-1:0] second_header,
  output logic                        res_valid,
  output hsld_pkg::hsld_result_t      res
);
  import hsld_pkg::*;

  localparam logic [1:0] ST_HUNT    = 2'd0;
  localparam logic [1:0] ST_LEN     = 2'd1;
  localparam logic [1:0] ST_PAYLOAD = 2'd2;

  logic [1:0]          state_r, state_nxt;
  logic [BYTE_W-1:0]   held_byte_r, held_byte_nxt;
  logic                held_valid_r, held_valid_nxt;
  logic [OFFSET_W-1:0] frame_index_r, frame_index_nxt;
  logic [BYTE_W-1:0]   payload_count_r, payload_count_nxt;
  logic [OFFSET_W-1:0] total_length_r, total_length_nxt;
  logic                pay_last;

  assign pay_last = ({1'b0, frame_index_r} + {{OFFSET_W{1'b0}}, 1'b1}) >=
                    {1'b0, total_length_r};

  always_comb begin
    state_nxt         = state_r;
    held_byte_nxt     = held_byte_r;
    held_valid_nxt    = held_valid_r;
    frame_index_nxt   = frame_index_r;
    payload_count_nxt = payload_count_r;
    total_length_nxt  = total_length_r;
    res_valid         = 1'b0;
    res.frame_byte      = rx_byte;
    res.byte_offset     = frame_index_r;
    res.declared_length = payload_count_r;
    res.frame_last      = 1'b0;
    case (state_r)
      ST_HUNT: begin
        if (held_valid_r && held_byte_r == first_header && rx_byte == second_header) begin
          state_nxt       = ST_LEN;
          held_valid_nxt  = 1'b0;
          frame_index_nxt = LEN_BYTE_OFFSET;
        end else begin
          held_byte_nxt  = rx_byte;
          held_valid_nxt = 1'b1;
        end
      end
      ST_LEN: begin
        payload_count_nxt   = rx_byte;
        total_length_nxt    = FRAME_OVERHEAD + {1'b0, rx_byte};
        res_valid           = 1'b1;
        res.byte_offset     = LEN_BYTE_OFFSET;
        res.declared_length = rx_byte;
        if (rx_byte == '0) begin
          res.frame_last  = 1'b1;
          state_nxt       = ST_HUNT;
          held_valid_nxt  = 1'b0;
          frame_index_nxt = '0;
        end else begin
          state_nxt       = ST_PAYLOAD;
          frame_index_nxt = FIRST_PAY_OFFSET;
        end
      end
      ST_PAYLOAD: begin
        res_valid      = 1'b1;
        res.frame_last = pay_last;
        if (pay_last) begin
          state_nxt       = ST_HUNT;
          held_valid_nxt  = 1'b0;
          frame_index_nxt = '0;
        end else begin
          frame_index_nxt = frame_index_r + {{(OFFSET_W-1){1'b0}}, 1'b1};
        end
      end
      default: begin
        state_nxt      = ST_HUNT;
        held_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_HUNT;
      held_valid_r    <= 1'b0;
      frame_index_r   <= '0;
      payload_count_r <= '0;
      total_length_r  <= '0;
    end else if (step_en) begin
      state_r         <= state_nxt;
      held_valid_r    <= held_valid_nxt;
      frame_index_r   <= frame_index_nxt;
      payload_count_r <= payload_count_nxt;
      total_length_r  <= total_length_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      held_byte_r <= held_byte_nxt;
    end
  end

  a_no_result_while_hunting: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HUNT) |-> !res_valid)
    else $error("result produced while hunting for the header");

  a_payload_index_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PAYLOAD) |->
      (frame_index_r >= FIRST_PAY_OFFSET && frame_index_r < total_length_r))
    else $error("payload index outside the declared frame");

  a_last_returns_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && res_valid && res.frame_last) |=> (state_r == ST_HUNT && !held_valid_r))
    else $error("frame end did not return to hunting with no byte held");

  a_match_enters_len: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && state_r == ST_HUNT && state_nxt == ST_LEN) |=>
      (frame_index_r == LEN_BYTE_OFFSET && !held_valid_r))
    else $error("header match did not set up the length byte");

endmodule

### design/header_sync_length_deframer.sv
// Top level of the header sync length deframer: config registers, input
// register, frame state machine and output register.
// Depends on hsld_pkg, hsld_in_reg and hsld_core.
//
// The block takes one received byte per cycle, unless the output stalls, and
// finds frames that open with two configured header bytes followed by a
// length byte L. Header bytes give no item out; the length byte and the L
// payload bytes each give one item with the byte, its offset in the frame (2
// for the length byte), L and a last mark on tlast. A zero length ends the
// frame at the length byte. After a frame the two header bytes must arrive
// fresh. Throughput is one byte per clock cycle while out_tready stays high.
// A byte is processed from the input register by the frame state machine, and
// its item is held in the output register until it is taken. While out_tready
// is low with an item waiting, the input register holds its byte and in_tready
// stays low until the item is taken. Header values are written through the
// cfg port, index 0 for the first header byte and index 1 for the second;
// other indexes are ignored.
module header_sync_length_deframer (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [hsld_pkg::BYTE_W-1:0]         in_tdata,   // [7:0] rx_byte
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [7:0] frame_byte, [16:8] byte_offset, [24:17] declared_length, [31:25] zero
  output logic [hsld_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                                out_tlast,  // frame_last
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [hsld_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [hsld_pkg::BYTE_W-1:0]         cfg_data
);
  import hsld_pkg::*;

  logic [BYTE_W-1:0] first_header_r;
  logic [BYTE_W-1:0] second_header_r;
  logic              in_valid_r;
  logic [BYTE_W-1:0] in_byte_r;
  logic              step_en;
  logic              res_valid;
  hsld_result_t      res;
  logic              out_valid_r, out_valid_nxt;
  hsld_result_t      out_res_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_header_r  <= '0;
      second_header_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_FIRST_HEADER) begin
        first_header_r <= cfg_data;
      end else if (cfg_index == CFG_SECOND_HEADER) begin
        second_header_r <= cfg_data;
      end
    end
  end

  assign step_en = in_valid_r && (!out_valid_r || out_tready);

  hsld_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_byte   (in_tdata),
    .take      (step_en),
    .valid_r   (in_valid_r),
    .byte_r    (in_byte_r)
  );

  hsld_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .step_en       (step_en),
    .rx_byte       (in_byte_r),
    .first_header  (first_header_r),
    .second_header (second_header_r),
    .res_valid     (res_valid),
    .res           (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (step_en) begin
      out_valid_nxt = res_valid;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_res_r.frame_last;
  assign out_tdata  = {{(OUT_DATA_W - 2*BYTE_W - OFFSET_W){1'b0}},
                       out_res_r.declared_length,
                       out_res_r.byte_offset,
                       out_res_r.frame_byte};

endmodule

### bench/tb_header_sync_length_deframer.sv
// Self-checking testbench for header_sync_length_deframer: drives received bytes
// with random gaps and back-pressure and checks each item against a local frame tracker.
// Depends on hsld_pkg and the header_sync_length_deframer RTL.
module tb_header_sync_length_deframer;
  import hsld_pkg::*;

  localparam int unsigned MAX_GAP       = 18;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned RANDOM_ITEMS  = 60;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [BYTE_W-1:0]     in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [BYTE_W-1:0]     cfg_data   = '0;

  // Frame tracker state, mirroring the block after reset.
  logic [BYTE_W-1:0]   hdr_first_q  = '0;
  logic [BYTE_W-1:0]   hdr_second_q = '0;
  bit                  synced       = 1'b0;
  logic [BYTE_W-1:0]   held         = '0;
  bit                  held_ok      = 1'b0;
  logic [OFFSET_W-1:0] next_off     = '0;
  bit                  len_taken    = 1'b0;
  logic [BYTE_W-1:0]   pay_len      = '0;
  logic [OFFSET_W-1:0] frame_total  = '0;

  hsld_result_t pending_frame_bytes[$];

  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;
  int unsigned sent_count  = 0;
  int unsigned gap_left    = 0;
  bit          tx_burst    = 1'b0;
  bit          rx_burst    = 1'b0;

  header_sync_length_deframer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic void restart_hunt();
    synced    = 1'b0;
    held_ok   = 1'b0;
    held      = '0;
    next_off  = '0;
    len_taken = 1'b0;
  endfunction

  function automatic void track_rx_byte(input logic [BYTE_W-1:0] b);
    hsld_result_t r;
    if (!synced) begin
      if (held_ok && held == hdr_first_q && b == hdr_second_q) begin
        synced    = 1'b1;
        held_ok   = 1'b0;
        next_off  = LEN_BYTE_OFFSET;
        len_taken = 1'b0;
      end else begin
        held    = b;
        held_ok = 1'b1;
      end
      return;
    end
    r.frame_byte = b;
    if (!len_taken) begin
      pay_len           = b;
      frame_total       = FRAME_OVERHEAD + OFFSET_W'(b);
      r.byte_offset     = LEN_BYTE_OFFSET;
      r.declared_length = b;
      r.frame_last      = (b == '0);
      if (b == '0) begin
        restart_hunt();
      end else begin
        len_taken = 1'b1;
        next_off  = FIRST_PAY_OFFSET;
      end
    end else begin
      r.byte_offset     = next_off;
      r.declared_length = pay_len;
      r.frame_last      = (int'(next_off) + 1 >= int'(frame_total));
      if (r.frame_last) begin
        restart_hunt();
      end else begin
        next_off = next_off + 1'b1;
      end
    end
    pending_frame_bytes.push_back(r);
  endfunction

  always @(posedge clk) begin : out_monitor
    hsld_result_t want;
    int unsigned gap;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (out_tvalid && out_tready) begin
      if (pending_frame_bytes.size() == 0) begin
        $error("unexpected item: tdata=%h tlast=%b", out_tdata, out_tlast);
        fail_count++;
      end else begin
        want = pending_frame_bytes.pop_front();
        if (out_tdata[7:0] !== want.frame_byte) begin
          $error("frame_byte: expected %0d, got %0d", want.frame_byte, out_tdata[7:0]);
          fail_count++;
        end
        if (out_tdata[16:8] !== want.byte_offset) begin
          $error("byte_offset: expected %0d, got %0d", want.byte_offset, out_tdata[16:8]);
          fail_count++;
        end
        if (out_tdata[24:17] !== want.declared_length) begin
          $error("declared_length: expected %0d, got %0d",
                 want.declared_length, out_tdata[24:17]);
          fail_count++;
        end
        if (out_tlast !== want.frame_last) begin
          $error("frame_last: expected %0d, got %0d", want.frame_last, out_tlast);
          fail_count++;
        end
        if (out_tdata[31:25] !== '0) begin
          $error("tdata padding: expected 0, got %0d", out_tdata[31:25]);
          fail_count++;
        end
      end
      if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
      gap = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
      out_tready <= (gap == 0);
      gap_left = gap;
    end else if (gap_left != 0) begin
      gap_left = gap_left - 1;
      out_tready <= (gap_left == 0);
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    track_rx_byte(b);
    sent_count++;
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_frame_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_FIRST_HEADER) begin
      hdr_first_q = value;
    end else if (idx == CFG_SECOND_HEADER) begin
      hdr_second_q = value;
    end
  endtask

  // Writes both header registers with an ignored index in between.
  task automatic set_headers(input logic [BYTE_W-1:0] h1, input logic [BYTE_W-1:0] h2);
    write_reg(CFG_FIRST_HEADER, h1);
    write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, BYTE_W'($urandom_range(0, 255)));
    write_reg(CFG_SECOND_HEADER, h2);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [BYTE_W-1:0] pick_byte(input logic [BYTE_W-1:0] h1,
                                                   input logic [BYTE_W-1:0] h2);
    case ($urandom_range(0, 7))
      0: return h1;
      1: return h2;
      default: return BYTE_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic test_reset_headers();
    send_byte(8'h00); send_byte(8'h00); send_byte(8'h01); send_byte(8'hFF);
    wait_idle();
  endtask

  task automatic test_sync_cases();
    set_headers(8'hA5, 8'h5A);
    // A sliding window ahead of a zero length frame.
    send_byte(8'h5A); send_byte(8'hA5); send_byte(8'hA5); send_byte(8'h5A); send_byte(8'h00);
    send_byte(8'hA5); send_byte(8'h5A); send_byte(8'h01); send_byte(8'hFF);
    send_byte(8'hA5); send_byte(8'h5A); send_byte(8'h03);
    send_byte(8'h00); send_byte(8'h80); send_byte(8'hA5);
    // The frame's last byte must not serve as the first header byte.
    send_byte(8'h5A); send_byte(8'h11);
    send_byte(8'hA5); send_byte(8'h5A); send_byte(8'h02); send_byte(8'hA5); send_byte(8'h5A);
    wait_idle();
  endtask

  task automatic test_max_length();
    set_headers(8'hFF, 8'h00);
    send_byte(8'hFF); send_byte(8'h00); send_byte(8'hFF);
    repeat (255) send_byte(pick_byte(8'hFF, 8'h00));
    wait_idle();
  endtask

  task automatic test_config_mid_frame();
    set_headers(8'h12, 8'h34);
    send_byte(8'h12); send_byte(8'h34); send_byte(8'h04); send_byte(8'hAA);
    wait_idle();
    set_headers(8'h56, 8'h78);
    send_byte(8'hBB); send_byte(8'hCC); send_byte(8'hDD);
    send_byte(8'h12); send_byte(8'h34);
    send_byte(8'h56); send_byte(8'h78); send_byte(8'h00);
    wait_idle();
  endtask

  task automatic run_random_traffic(input logic [BYTE_W-1:0] h1, input logic [BYTE_W-1:0] h2);
    int unsigned stop_at;
    int unsigned len;
    int unsigned roll;
    set_headers(h1, h2);
    stop_at = sent_count + RANDOM_ITEMS;
    while (sent_count < stop_at) begin
      if ($urandom_range(0, 3) != 0) begin
        roll = $urandom_range(0, 99);
        len  = (roll < 10) ? 0 : (roll < 90) ? $urandom_range(1, 8) : $urandom_range(9, 40);
        send_byte(h1);
        send_byte(h2);
        send_byte(BYTE_W'(len));
        repeat (len) send_byte(pick_byte(h1, h2));
      end else begin
        repeat ($urandom_range(1, 4)) send_byte(pick_byte(h1, h2));
      end
    end
    wait_idle();
  endtask

  task automatic test_random_headers();
    logic [BYTE_W-1:0] same;
    same = BYTE_W'($urandom_range(0, 255));
    run_random_traffic(8'h00, 8'h00);
    run_random_traffic(8'hFF, 8'hFF);
    run_random_traffic(8'hFF, 8'h00);
    run_random_traffic(8'h00, 8'hFF);
    run_random_traffic(same, same);
    run_random_traffic(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)));
    run_random_traffic(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)));
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_headers();
    test_sync_cases();
    test_max_length();
    test_config_mid_frame();
    test_random_headers();
    wait_idle();
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### header_sync_length_deframer.f
design/hsld_pkg.sv
design/hsld_in_reg.sv
design/hsld_core.sv
design/header_sync_length_deframer.sv
bench/tb_header_sync_length_deframer.sv
